// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// condition implies consequence in the same cycle
`define ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

// ----- hw/rtl/citi_pkg.sv -----
// package: constants, types and helpers of the collision integral interpolator
package citi_pkg;
   localparam int TEMP_POINTS   = 37;
   localparam int DIPOLE_POINTS = 8;
   localparam int FRAC_BITS     = 20;
   localparam int TEMP_AW       = $clog2(TEMP_POINTS);
   localparam int DIP_AW        = $clog2(DIPOLE_POINTS);
   localparam int OMEGA_DEPTH   = 2 * TEMP_POINTS * DIPOLE_POINTS;
   localparam int OMEGA_AW      = $clog2(OMEGA_DEPTH);

   typedef enum logic [1:0] {
      CMD_WR_TEMP  = 2'd0,
      CMD_WR_DIP   = 2'd1,
      CMD_WR_TABLE = 2'd2,
      CMD_QUERY    = 2'd3
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_TSRCH, ST_TWAIT, ST_DSRCH, ST_DWAIT, ST_GRID,
      ST_FIT_SETUP, ST_DIV, ST_MUL1, ST_MUL2, ST_MUL3, ST_NEXT_TERM,
      ST_FIT_END, ST_OMEGA, ST_OMEGA_WAIT, ST_DONE
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      else if (v < -66'sd2147483648) return 32'sh80000000;
      else return v[31:0];
   endfunction

   function automatic logic is_sat(input logic signed [65:0] v);
      return (v > 66'sd2147483647) || (v < -66'sd2147483648);
   endfunction
endpackage

// ----- hw/rtl/citi_ram.sv -----
// generic single port ram with registered read
module citi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule

// ----- hw/rtl/citi_divider.sv -----
// signed restoring divider, one quotient bit per cycle, truncating toward zero
module citi_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [32:0] num,
   input  logic signed [32:0] den,
   output logic               done,
   output logic signed [65:0] quot
);
   import citi_pkg::*;
   localparam int NW = 33 + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [33:0]   r_ff, r_in;
   logic [32:0]   d_ff, d_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [33:0]   trial;
   logic [32:0]   an, ad;

   always_comb begin
      an = num[32] ? 33'(-num) : num;
      ad = den[32] ? 33'(-den) : den;
      q_in = q_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[32:0], q_ff[NW-1]};
      if (start) begin
         q_in = {an, {FRAC_BITS{1'b0}}};
         r_in = '0;
         d_in = ad;
         neg_in = num[32] ^ den[32];
         cnt_in = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed(66'(q_ff)) : $signed(66'(q_ff));
endmodule

// ----- hw/rtl/collision_integral_table_interp.sv -----
// top level: biquadratic collision integral table interpolator
// The two linear grid scans read every grid point in turn, temperature first, then
// dipole. ST_GRID fetches the three temperature and three dipole nodes. Each of the
// four three-node fits makes six serial divisions in the shared bit-serial divider,
// plus the weight and term multiplies; a fit whose nodes coincide skips them. The
// nine table reads each pass through ST_OMEGA and ST_OMEGA_WAIT, and ST_DONE hands
// the column values to the final fit. Write transactions are accepted one per cycle
// while no query is in work. Grids and tables sit in single-port rams with registered
// reads; reading an entry never written gives undefined data. One item is in work at
// a time. The finished result is held in an output register until it is taken. A new
// transaction may be accepted while that result waits, but the next result is held
// back until the previous one has gone.
module collision_integral_table_interp (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_command,
   input  logic                req_table_select,
   input  logic [5:0]          req_row_index,
   input  logic [2:0]          req_column_index,
   input  logic signed [31:0]  req_load_value,
   input  logic signed [31:0]  req_query_reduced_temp,
   input  logic signed [31:0]  req_query_reduced_dipole,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_omega,
   output logic                rsp_saturated
);
   import citi_pkg::*;
`include "assert_macros.svh"

   state_type state_ff, state_in;

   // latched query
   logic              sel_ff, sel_in;
   logic signed [31:0] t_ff, t_in, d_ff, d_in;
   logic [TEMP_AW-1:0] ti_ff, ti_in, tscan_ff, tscan_in;
   logic [DIP_AW-1:0]  tj_ff, tj_in, dscan_ff, dscan_in;
   logic signed [31:0] g0_ff, g0_in;
   logic               found_ff, found_in;
   logic [1:0]         gk_ff, gk_in;     // node count for grid / omega loads
   logic [1:0]         col_ff, col_in;   // 0..2 columns, 3 final fit
   logic [1:0]         term_ff, term_in;
   logic               rsel_ff, rsel_in; // which ratio of the term
   logic signed [31:0] xn_ff [3], xn_in [3];
   logic signed [31:0] yn_ff [3], yn_in [3];
   logic signed [31:0] tx_ff [3], tx_in [3]; // temp nodes
   logic signed [31:0] cv_ff [3], cv_in [3];
   logic signed [31:0] r1_ff, r1_in, w_ff, w_in;
   logic signed [65:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic               flag_ff, flag_in;
   logic               rv_ff, rv_in;
   logic signed [31:0] ro_ff, ro_in;
   logic               rs_ff, rs_in;

   // memories
   logic                 tg_we, dg_we, om_we;
   logic [TEMP_AW-1:0]   tg_a;
   logic [DIP_AW-1:0]    dg_a;
   logic [OMEGA_AW-1:0]  om_a;
   logic [31:0]          tg_q, dg_q, om_q;

   citi_ram #(.WIDTH(32), .DEPTH(TEMP_POINTS)) u_tg (
      .clock, .wr_en(tg_we), .addr(tg_a), .wr_data(req_load_value), .rd_data(tg_q));
   citi_ram #(.WIDTH(32), .DEPTH(DIPOLE_POINTS)) u_dg (
      .clock, .wr_en(dg_we), .addr(dg_a), .wr_data(req_load_value), .rd_data(dg_q));
   citi_ram #(.WIDTH(32), .DEPTH(OMEGA_DEPTH)) u_om (
      .clock, .wr_en(om_we), .addr(om_a), .wr_data(req_load_value), .rd_data(om_q));

   logic               div_start, div_done;
   logic signed [32:0] div_num, div_den;
   logic signed [65:0] div_q;
   citi_divider u_div (.clock, .reset, .start(div_start), .num(div_num),
      .den(div_den), .done(div_done), .quot(div_q));

   logic accept;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // node index k for term i
   logic [1:0] kn;
   logic signed [31:0] xq;
   logic [TEMP_AW-1:0] orow;
   logic [OMEGA_AW+1:0] oidx;
   logic signed [63:0] ymul;

   always_comb begin
      case (term_ff)
         2'd0:    kn = 2'd2;
         2'd1:    kn = 2'd2;
         default: kn = 2'd1;
      endcase
      xq = (col_ff == 2'd3) ? d_ff : t_ff;
      orow = ti_ff + TEMP_AW'(gk_ff);
      oidx = (OMEGA_AW+2)'(((32'(sel_ff) * TEMP_POINTS + 32'(orow)) * DIPOLE_POINTS)
             + 32'(tj_ff) + 32'(col_ff));
      ymul = $signed(64'(yn_ff[term_ff])) * $signed(64'(w_ff));
   end

   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff; t_in = t_ff; d_in = d_ff; ti_in = ti_ff; tj_in = tj_ff;
      tscan_in = tscan_ff; dscan_in = dscan_ff; g0_in = g0_ff; found_in = found_ff;
      gk_in = gk_ff; col_in = col_ff; term_in = term_ff; rsel_in = rsel_ff;
      xn_in = xn_ff; yn_in = yn_ff; tx_in = tx_ff; cv_in = cv_ff;
      r1_in = r1_ff; w_in = w_ff; acc_in = acc_ff; prod_in = prod_ff;
      flag_in = flag_ff; rv_in = rv_ff; ro_in = ro_ff; rs_in = rs_ff;
      tg_we = 1'b0; dg_we = 1'b0; om_we = 1'b0;
      tg_a = tscan_ff; dg_a = dscan_ff; om_a = oidx[OMEGA_AW-1:0];
      div_start = 1'b0;
      div_num = '0; div_den = '0;

      if (rv_ff && !rsp_stall) rv_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd_type'(req_command))
                  CMD_WR_TEMP: begin
                     tg_a = req_row_index[TEMP_AW-1:0];
                     tg_we = (32'(req_row_index) < TEMP_POINTS);
                  end
                  CMD_WR_DIP: begin
                     dg_a = req_column_index[DIP_AW-1:0];
                     dg_we = (32'(req_column_index) < DIPOLE_POINTS);
                  end
                  CMD_WR_TABLE: begin
                     om_a = OMEGA_AW'(((32'(req_table_select) * TEMP_POINTS
                            + 32'(req_row_index)) * DIPOLE_POINTS) + 32'(req_column_index));
                     om_we = (32'(req_row_index) < TEMP_POINTS)
                             && (32'(req_column_index) < DIPOLE_POINTS);
                  end
                  default: begin
                     sel_in = req_table_select;
                     t_in = req_query_reduced_temp;
                     d_in = req_query_reduced_dipole;
                     flag_in = 1'b0;
                     tscan_in = '0;
                     tg_a = '0;
                     found_in = 1'b0;
                     ti_in = TEMP_AW'(TEMP_POINTS - 3);
                     state_in = ST_TWAIT;
                  end
               endcase
            end
         end
         // scan temp grid: address tscan read, data arrives next cycle
         ST_TWAIT: begin
            tg_a = tscan_ff;
            state_in = ST_TSRCH;
         end
         ST_TSRCH: begin
            if (tscan_ff == '0) g0_in = tg_q;
            if (tscan_ff == TEMP_AW'(TEMP_POINTS - 1)) begin
               // last point decides bracket class
               if (t_ff <= g0_ff) ti_in = '0;
               else if (t_ff < $signed(tg_q) && found_ff) ti_in = ti_ff;
               else ti_in = TEMP_AW'(TEMP_POINTS - 3);
               dscan_in = '0;
               found_in = 1'b0;
               state_in = ST_DWAIT;
            end else begin
               if (tscan_ff != '0 && !found_ff && t_ff <= $signed(tg_q)) begin
                  found_in = 1'b1;
                  ti_in = (tscan_ff - 1'b1 > TEMP_AW'(TEMP_POINTS - 3))
                          ? TEMP_AW'(TEMP_POINTS - 3) : tscan_ff - 1'b1;
               end
               tscan_in = tscan_ff + 1'b1;
               state_in = ST_TWAIT;
            end
            // if never found before last, i stops at n-1 -> clamp n-3
            if (tscan_ff == TEMP_AW'(TEMP_POINTS - 1) && !found_ff
                && t_ff > g0_ff && t_ff < $signed(tg_q))
               ti_in = TEMP_AW'(TEMP_POINTS - 3);
         end
         ST_DWAIT: begin
            dg_a = dscan_ff;
            state_in = ST_DSRCH;
         end
         ST_DSRCH: begin
            if (dscan_ff == '0) g0_in = dg_q;
            if (dscan_ff == DIP_AW'(DIPOLE_POINTS - 1)) begin
               if (d_ff <= g0_ff) tj_in = '0;
               else if (d_ff < $signed(dg_q) && found_ff) tj_in = tj_ff;
               else tj_in = DIP_AW'(DIPOLE_POINTS - 3);
               gk_in = '0;
               tscan_in = ti_ff;
               state_in = ST_GRID;
            end else begin
               if (dscan_ff != '0 && !found_ff && d_ff <= $signed(dg_q)) begin
                  found_in = 1'b1;
                  tj_in = (dscan_ff - 1'b1 > DIP_AW'(DIPOLE_POINTS - 3))
                          ? DIP_AW'(DIPOLE_POINTS - 3) : dscan_ff - 1'b1;
               end
               dscan_in = dscan_ff + 1'b1;
               state_in = ST_DWAIT;
            end
         end
         // fetch the three temp nodes and three dipole nodes
         ST_GRID: begin
            tg_a = ti_ff + TEMP_AW'(gk_ff);
            dg_a = tj_ff + DIP_AW'(gk_ff);
            if (gk_ff != '0) begin
               tx_in[gk_ff - 2'd1] = tg_q;
               cv_in[gk_ff - 2'd1] = dg_q; // dipole nodes parked until fits done
            end
            if (gk_ff == 2'd3) begin
               col_in = '0;
               gk_in = '0;
               state_in = ST_OMEGA;
            end else begin
               gk_in = gk_ff + 2'd1;
            end
         end
         ST_OMEGA: begin
            state_in = ST_OMEGA_WAIT;
         end
         ST_OMEGA_WAIT: begin
            yn_in[gk_ff] = om_q;
            if (gk_ff == 2'd2) begin
               xn_in = tx_ff;
               state_in = ST_FIT_SETUP;
            end else begin
               gk_in = gk_ff + 2'd1;
               state_in = ST_OMEGA;
            end
         end
         ST_FIT_SETUP: begin
            acc_in = '0;
            term_in = '0;
            rsel_in = 1'b0;
            if (xn_ff[0] == xn_ff[1] || xn_ff[0] == xn_ff[2] || xn_ff[1] == xn_ff[2]) begin
               acc_in = 66'(yn_ff[1]);
               state_in = ST_FIT_END;
            end else begin
               div_start = 1'b1;
               div_num = 33'(xq) - 33'(xn_ff[1]);
               div_den = 33'(xn_ff[0]) - 33'(xn_ff[1]);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (is_sat(div_q)) flag_in = 1'b1;
               if (!rsel_ff) begin
                  r1_in = sat32(div_q);
                  rsel_in = 1'b1;
                  div_start = 1'b1;
                  div_num = 33'(xq) - 33'(xn_ff[kn]);
                  div_den = 33'(xn_ff[term_ff]) - 33'(xn_ff[kn]);
               end else begin
                  prod_in = 64'(r1_ff) * 64'(sat32(div_q));
                  state_in = ST_MUL1;
               end
            end
         end
         ST_MUL1: begin
            if (is_sat(66'(prod_ff >>> FRAC_BITS))) flag_in = 1'b1;
            w_in = sat32(66'(prod_ff >>> FRAC_BITS));
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            prod_in = ymul;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            acc_in = acc_ff + 66'(prod_ff >>> FRAC_BITS);
            state_in = ST_NEXT_TERM;
         end
         ST_NEXT_TERM: begin
            if (term_ff == 2'd2) begin
               if (is_sat(acc_ff)) flag_in = 1'b1;
               acc_in = 66'(sat32(acc_ff));
               state_in = ST_FIT_END;
            end else begin
               // terms one and two both pair with node zero first
               term_in = term_ff + 2'd1;
               rsel_in = 1'b0;
               div_start = 1'b1;
               div_num = 33'(xq) - 33'(xn_ff[2'd0]);
               div_den = 33'(xn_ff[term_ff + 2'd1]) - 33'(xn_ff[2'd0]);
               state_in = ST_DIV;
            end
         end
         ST_FIT_END: begin
            if (col_ff == 2'd3) begin
               // a new result waits until the previous one is taken
               if (!rv_ff || !rsp_stall) begin
                  ro_in = acc_ff[31:0];
                  rs_in = flag_ff;
                  rv_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               // column value written to yn slot after fit; dipole nodes in cv
               yn_in[col_ff] = acc_ff[31:0];
               tx_in[col_ff] = tx_ff[col_ff];
               if (col_ff == 2'd2) begin
                  xn_in = cv_ff;
                  yn_in[0] = yn_ff[0];
                  col_in = 2'd3;
                  state_in = ST_DONE;
               end else begin
                  col_in = col_ff + 2'd1;
                  gk_in = '0;
                  state_in = ST_OMEGA;
               end
               cv_in = cv_ff;
            end
         end
         ST_DONE: begin
            state_in = ST_FIT_SETUP;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // column results are stashed separately so omega loads can reuse yn
   logic signed [31:0] colv_ff [3], colv_in [3];
   always_comb begin
      colv_in = colv_ff;
      if (state_ff == ST_FIT_END && col_ff != 2'd3) colv_in[col_ff] = acc_ff[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
      sel_ff <= sel_in; t_ff <= t_in; d_ff <= d_in; ti_ff <= ti_in; tj_ff <= tj_in;
      tscan_ff <= tscan_in; dscan_ff <= dscan_in; g0_ff <= g0_in;
      found_ff <= found_in; gk_ff <= gk_in; col_ff <= col_in; term_ff <= term_in;
      rsel_ff <= rsel_in; tx_ff <= tx_in; cv_ff <= cv_in;
      r1_ff <= r1_in; w_ff <= w_in; acc_ff <= acc_in; prod_ff <= prod_in;
      flag_ff <= flag_in; ro_ff <= ro_in; rs_ff <= rs_in; colv_ff <= colv_in;
      xn_ff <= xn_in;
      // final fit uses stashed column values
      if (state_ff == ST_DONE) yn_ff <= colv_ff;
      else yn_ff <= yn_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_omega = ro_ff;
   assign rsp_saturated = rs_ff;

   `ASSERT_IMPLY(a_stall_busy, clock, reset, state_ff != ST_IDLE, req_stall)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rv_ff && rsp_stall, rv_ff && $stable(ro_ff))
   `ASSERT_IMPLY(a_ti_range, clock, reset, state_ff == ST_GRID,
      ti_ff <= TEMP_AW'(TEMP_POINTS - 3) && tj_ff <= DIP_AW'(DIPOLE_POINTS - 3))
endmodule
